FILE: rtl/julia_escape_time_pixel_macros.svh
// Assertion macros shared by the Julia escape-time pixel RTL.
// Each macro expects clk and rst_n to be in scope at the point of use.
`ifndef JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/jet_pkg.sv
// Package for the Julia escape-time pixel block: sizes, state and register codes,
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package jet_pkg;

  localparam int PIXEL_BITS     = 10;
  localparam int COORD_BITS     = 10;
  localparam int MAX_ITER_LIMIT = 256;
  localparam int ITER_BITS      = 9;
  localparam int ZOOM_BITS      = 16;
  localparam int SPAN_BITS      = 9;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int Q_FRAC         = 28;
  localparam int ZOOM_FRAC      = 8;
  localparam int FIX_BITS       = 32;
  localparam int PROD_FULL_BITS = 2 * FIX_BITS;
  localparam int SUM_BITS       = 37;

  localparam int HALF_BITS = SPAN_BITS - 1;
  localparam int D_BITS    = (COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS;
  localparam int SCALE_BITS = 2;
  localparam int PROD_BITS = D_BITS + SCALE_BITS;
  localparam int NUM_BITS  = PROD_BITS + Q_FRAC + ZOOM_FRAC;
  localparam int DEN_BITS  = ZOOM_BITS + SPAN_BITS;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

  localparam logic [SCALE_BITS-1:0] SCALE_RE = SCALE_BITS'(3);
  localparam logic [SCALE_BITS-1:0] SCALE_IM = SCALE_BITS'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DINIT,
    S_DIV,
    S_SAVE,
    S_MUL,
    S_ADD
  } state_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ZOOM   = 3'd0,
    CFG_LIMIT  = 3'd1,
    CFG_CREAL  = 3'd2,
    CFG_CIMAG  = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_init;
    logic div_step;
    logic save;
    logic mul;
    logic upd;
    logic axis;
  } cmd_t;

  typedef struct packed {
    logic esc;
  } sts_t;

endpackage

FILE: rtl/jet_div.sv
// Restoring unsigned divider, one quotient bit per step, for coordinate mapping.
// Depends on jet_pkg for operand widths.
`timescale 1ns / 1ps

module jet_div (
  input  logic                         clk,
  input  logic                         init,
  input  logic                         step,
  input  logic [jet_pkg::NUM_BITS-1:0] numer,
  input  logic [jet_pkg::DEN_BITS-1:0] denom,
  output logic [jet_pkg::NUM_BITS-1:0] quot
);
  import jet_pkg::*;

  logic [DEN_BITS-1:0] rem_r;
  logic [DEN_BITS-1:0] rem_nxt;
  logic [NUM_BITS-1:0] quo_r;
  logic [NUM_BITS-1:0] quo_nxt;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_BITS-1]};
    ge      = shifted >= {1'b0, denom};
    diff    = shifted - {1'b0, denom};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (init) begin
      rem_nxt = '0;
      quo_nxt = numer;
    end else if (step) begin
      rem_nxt = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
      quo_nxt = {quo_r[NUM_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quot = quo_r;

endmodule

FILE: rtl/jet_dp.sv
// Datapath: coordinate mapping into Q4.28 through the divider, then z = z^2 + c.
// Depends on jet_pkg and jet_div; driven by commands from jet_ctrl.
`timescale 1ns / 1ps

module jet_dp (
  input  logic                            clk,
  input  jet_pkg::cmd_t                   cmd,
  output jet_pkg::sts_t                   sts,
  input  logic [jet_pkg::COORD_BITS-1:0]  pixel_x,
  input  logic [jet_pkg::COORD_BITS-1:0]  pixel_y,
  input  logic [jet_pkg::ZOOM_BITS-1:0]   zoom,
  input  logic [jet_pkg::SPAN_BITS-1:0]   span_x,
  input  logic [jet_pkg::SPAN_BITS-1:0]   span_y,
  input  logic signed [jet_pkg::FIX_BITS-1:0] const_re,
  input  logic signed [jet_pkg::FIX_BITS-1:0] const_im
);
  import jet_pkg::*;

  localparam logic signed [SUM_BITS-1:0] WMAX = SUM_BITS'(64'sd2147483647);
  localparam logic signed [SUM_BITS-1:0] WMIN = SUM_BITS'(-64'sd2147483648);
  localparam logic [PROD_FULL_BITS-1:0]  MAG_FOUR = 64'h0400_0000_0000_0000;

  logic [COORD_BITS-1:0] px_r;
  logic [COORD_BITS-1:0] py_r;
  logic [NUM_BITS-1:0]   num_r;
  logic [DEN_BITS-1:0]   den_r;
  logic                  neg_r;
  logic signed [FIX_BITS-1:0]       re_r;
  logic signed [FIX_BITS-1:0]       im_r;
  logic signed [PROD_FULL_BITS-1:0] prr_r;
  logic signed [PROD_FULL_BITS-1:0] pii_r;
  logic signed [PROD_FULL_BITS-1:0] pri_r;

  logic [SPAN_BITS-1:0]  span;
  logic [ZOOM_BITS-1:0]  zz;
  logic [D_BITS-1:0]     coord;
  logic [D_BITS-1:0]     half;
  logic [D_BITS-1:0]     delta;
  logic                  neg;
  logic [PROD_BITS-1:0]  prod;
  logic [NUM_BITS-1:0]   quot;
  logic [FIX_BITS-1:0]   mapped;
  logic signed [SUM_BITS-1:0] rr;
  logic signed [SUM_BITS-1:0] ii;
  logic signed [SUM_BITS-1:0] ri;
  logic signed [SUM_BITS-1:0] sum_re;
  logic signed [SUM_BITS-1:0] sum_im;
  logic signed [FIX_BITS-1:0] new_re;
  logic signed [FIX_BITS-1:0] new_im;
  logic [PROD_FULL_BITS-1:0]  mag;

  jet_div u_div (
    .clk   (clk),
    .init  (cmd.div_init),
    .step  (cmd.div_step),
    .numer (num_r),
    .denom (den_r),
    .quot  (quot)
  );

  always_comb begin
    span  = cmd.axis ? span_y : span_x;
    if (span == '0) begin
      span = SPAN_BITS'(1);
    end
    zz    = (zoom == '0) ? ZOOM_BITS'(1) : zoom;
    coord = D_BITS'(cmd.axis ? py_r : px_r);
    half  = D_BITS'(span >> 1);
    neg   = coord < half;
    delta = neg ? (half - coord) : (coord - half);
    prod  = PROD_BITS'(cmd.axis ? SCALE_IM : SCALE_RE) * PROD_BITS'(delta);
  end

  always_comb begin
    if (neg_r) begin
      mapped = (quot > NUM_BITS'(32'h8000_0000)) ? 32'h8000_0000 : (~quot[FIX_BITS-1:0] + 1'b1);
    end else begin
      mapped = (quot > NUM_BITS'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quot[FIX_BITS-1:0];
    end
  end

  always_comb begin
    rr     = SUM_BITS'(prr_r >>> Q_FRAC);
    ii     = SUM_BITS'(pii_r >>> Q_FRAC);
    ri     = SUM_BITS'(pri_r >>> Q_FRAC);
    sum_re = rr - ii + SUM_BITS'(const_re);
    sum_im = (ri <<< 1) + SUM_BITS'(const_im);
    if (sum_re > WMAX) begin
      new_re = 32'sh7FFF_FFFF;
    end else if (sum_re < WMIN) begin
      new_re = 32'sh8000_0000;
    end else begin
      new_re = sum_re[FIX_BITS-1:0];
    end
    if (sum_im > WMAX) begin
      new_im = 32'sh7FFF_FFFF;
    end else if (sum_im < WMIN) begin
      new_im = 32'sh8000_0000;
    end else begin
      new_im = sum_im[FIX_BITS-1:0];
    end
    mag     = $unsigned(prr_r) + $unsigned(pii_r);
    sts.esc = mag > MAG_FOUR;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= pixel_x;
      py_r <= pixel_y;
    end
    if (cmd.prep) begin
      num_r <= {prod, (Q_FRAC + ZOOM_FRAC)'(0)};
      den_r <= DEN_BITS'(zz) * DEN_BITS'(span);
      neg_r <= neg;
    end
    if (cmd.save) begin
      if (cmd.axis) begin
        im_r <= mapped;
      end else begin
        re_r <= mapped;
      end
    end else if (cmd.upd) begin
      re_r <= new_re;
      im_r <= new_im;
    end
    if (cmd.mul) begin
      prr_r <= re_r * re_r;
      pii_r <= im_r * im_r;
      pri_r <= re_r * im_r;
    end
  end

endmodule

FILE: rtl/jet_ctrl.sv
// Controller state machine: sequences mapping, division and iterations, and
// registers the result. Depends on jet_pkg and the assertion macro header.
`timescale 1ns / 1ps

module jet_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [jet_pkg::ITER_BITS-1:0] limit_cfg,
  input  jet_pkg::sts_t                 sts,
  output logic                          busy,
  output jet_pkg::cmd_t                 cmd,
  output logic                          out_valid,
  output logic [jet_pkg::ITER_BITS-1:0] out_count,
  output logic                          out_escaped
);
  import jet_pkg::*;
  `include "julia_escape_time_pixel_macros.svh"

  state_t                  state_r, state_nxt;
  logic                    axis_r, axis_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [ITER_BITS-1:0]    k_r, k_nxt;
  logic [ITER_BITS-1:0]    lim_r, lim_nxt;
  logic                    ov_r, ov_nxt;
  logic [ITER_BITS-1:0]    oc_r, oc_nxt;
  logic                    oe_r, oe_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 1'b0;
      cnt_r   <= '0;
      k_r     <= '0;
      lim_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      lim_r   <= lim_nxt;
      ov_r    <= ov_nxt;
    end
    oc_r <= oc_nxt;
    oe_r <= oe_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    lim_nxt   = lim_r;
    ov_nxt    = 1'b0;
    oc_nxt    = oc_r;
    oe_nxt    = oe_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          lim_nxt   = (limit_cfg > ITER_BITS'(MAX_ITER_LIMIT)) ?
                      ITER_BITS'(MAX_ITER_LIMIT) : limit_cfg;
          axis_nxt  = 1'b0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_CNT_BITS'(NUM_BITS - 1)) begin
          state_nxt = S_SAVE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SAVE: begin
        cmd.save = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = S_PREP;
        end else begin
          k_nxt     = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (k_r != '0 && sts.esc) begin
          ov_nxt    = 1'b1;
          oc_nxt    = k_r - 1'b1;
          oe_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (k_r == lim_r) begin
          ov_nxt    = 1'b1;
          oc_nxt    = k_r;
          oe_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          cmd.upd   = 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = ov_r;
  assign out_count   = oc_r;
  assign out_escaped = oe_r;

  `JET_ASSERT_SAME(a_result_after_add, ov_r, $past(state_r == S_ADD), "result without iteration end")
  `JET_ASSERT_NEXT(a_start_to_prep, start && (state_r == S_IDLE), state_r == S_PREP, "start not taken")
  `JET_ASSERT_SAME(a_count_in_limit, state_r == S_MUL || state_r == S_ADD, k_r <= lim_r, "count over limit")
  `JET_ASSERT_SAME(a_escape_below_limit, ov_r && oe_r, oc_r < lim_r, "escape index at or over limit")

endmodule

FILE: rtl/julia_escape_time_pixel.sv
// Top level of the Julia escape-time pixel block: configuration registers and
// the controller and datapath. Depends on jet_pkg, jet_ctrl and jet_dp.
`timescale 1ns / 1ps

// Usage:
// A pixel item (in_pixel_x, in_pixel_y) is taken at a rising edge where start is high
// and busy is low. The result item (out_iteration_count, out_escaped) appears for one
// cycle with out_valid high; the receiver cannot stall it and must take it then.
// Configuration registers are written through cfg_valid, cfg_index and cfg_data;
// cfg_ready is always high. Write only while no item is in progress.
// Each item maps x and then y through the shared one-bit-per-cycle divider
// (setup, init, 48 steps, save), then runs z squared plus c iterations, each a
// multiply state and an add state, until it escapes or reaches the limit.
// Busy drops in the cycle the result is shown, so a new item can be taken then.
// Synchronous reset restores the register defaults (zoom 3.0, limit 64, c of about
// -0.7 + 0.27015i, view 40 by 20) and abandons any item in progress.

module julia_escape_time_pixel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [jet_pkg::PIXEL_BITS-1:0]    in_pixel_x,
  input  logic [jet_pkg::PIXEL_BITS-1:0]    in_pixel_y,
  output logic                              out_valid,
  output logic [jet_pkg::ITER_BITS-1:0]     out_iteration_count,
  output logic                              out_escaped,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jet_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [jet_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import jet_pkg::*;

  logic [ZOOM_BITS-1:0]       zoom_r;
  logic [ITER_BITS-1:0]       limit_r;
  logic signed [FIX_BITS-1:0] creal_r;
  logic signed [FIX_BITS-1:0] cimag_r;
  logic [SPAN_BITS-1:0]       width_r;
  logic [SPAN_BITS-1:0]       height_r;
  cmd_t                       cmd;
  sts_t                       sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r   <= ZOOM_BITS'(768);
      limit_r  <= ITER_BITS'(64);
      creal_r  <= -32'sd187904819;
      cimag_r  <= 32'sd72517838;
      width_r  <= SPAN_BITS'(40);
      height_r <= SPAN_BITS'(20);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ZOOM:   zoom_r   <= cfg_data[ZOOM_BITS-1:0];
        CFG_LIMIT:  limit_r  <= cfg_data[ITER_BITS-1:0];
        CFG_CREAL:  creal_r  <= cfg_data;
        CFG_CIMAG:  cimag_r  <= cfg_data;
        CFG_WIDTH:  width_r  <= cfg_data[SPAN_BITS-1:0];
        CFG_HEIGHT: height_r <= cfg_data[SPAN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  jet_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .limit_cfg   (limit_r),
    .sts         (sts),
    .busy        (busy),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_count   (out_iteration_count),
    .out_escaped (out_escaped)
  );

  jet_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .sts      (sts),
    .pixel_x  (in_pixel_x[COORD_BITS-1:0]),
    .pixel_y  (in_pixel_y[COORD_BITS-1:0]),
    .zoom     (zoom_r),
    .span_x   (width_r),
    .span_y   (height_r),
    .const_re (creal_r),
    .const_im (cimag_r)
  );

endmodule

FILE: bench/julia_escape_time_pixel_tb.sv
// Self-checking bench for julia_escape_time_pixel: predicts escape counts per pixel,
// drives pixel items and register writes, and checks every result strobe.
// Depends on jet_pkg and the julia_escape_time_pixel RTL.
`timescale 1ns / 1ps

module julia_escape_time_pixel_tb;
  import jet_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 700;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;
  localparam longint Q_MAX = 64'sh7FFFFFFF;
  localparam longint Q_MIN = -64'sh80000000;
  localparam longint unsigned ESCAPE_BOUND = 64'd1 << 58;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] x;
    logic [PIXEL_BITS-1:0] y;
    logic [ITER_BITS-1:0]  count;
    logic                  escaped;
  } escape_t;

  class escape_tracker;
    escape_t expected_escapes[$];
    int errors;
    logic [ZOOM_BITS-1:0] zoom;
    logic [ITER_BITS-1:0] limit;
    longint c_re;
    longint c_im;
    logic [SPAN_BITS-1:0] width;
    logic [SPAN_BITS-1:0] height;

    function new();
      errors = 0;
      zoom = 16'd768;
      limit = 9'd64;
      c_re = -187904819;
      c_im = 72517838;
      width = 9'd40;
      height = 9'd20;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_ZOOM:   zoom = data[ZOOM_BITS-1:0];
        CFG_LIMIT:  limit = data[ITER_BITS-1:0];
        CFG_CREAL:  c_re = $signed(data);
        CFG_CIMAG:  c_im = $signed(data);
        CFG_WIDTH:  width = data[SPAN_BITS-1:0];
        CFG_HEIGHT: height = data[SPAN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint sat_q428(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function longint map_axis(logic [COORD_BITS-1:0] coord, logic [SPAN_BITS-1:0] span,
                              longint unsigned scale);
      longint unsigned s, zm, half, d, q;
      bit neg;
      s = (span == 0) ? 64'd1 : 64'(span);
      zm = (zoom == 0) ? 64'd1 : 64'(zoom);
      half = s / 2;
      neg = 64'(coord) < half;
      d = neg ? half - 64'(coord) : 64'(coord) - half;
      q = ((scale * d) << (Q_FRAC + ZOOM_FRAC)) / (zm * s);
      if (neg) return (q > (64'd1 << 31)) ? Q_MIN : -longint'(q);
      return (q > 64'd2147483647) ? Q_MAX : longint'(q);
    endfunction

    function void note_pixel(logic [PIXEL_BITS-1:0] x, logic [PIXEL_BITS-1:0] y);
      longint re, im, rr, ii, ri, nre, nim;
      longint unsigned mag;
      int i, lim;
      bit out;
      escape_t e;
      lim = (limit > MAX_ITER_LIMIT) ? MAX_ITER_LIMIT : int'(limit);
      re = map_axis(x[COORD_BITS-1:0], width, 64'(SCALE_RE));
      im = map_axis(y[COORD_BITS-1:0], height, 64'(SCALE_IM));
      i = 0;
      out = 1'b0;
      while (i < lim && !out) begin
        rr = (re * re) >>> Q_FRAC;
        ii = (im * im) >>> Q_FRAC;
        ri = (re * im) >>> Q_FRAC;
        nre = sat_q428(rr - ii + c_re);
        nim = sat_q428(2 * ri + c_im);
        mag = longint'(nre * nre) + longint'(nim * nim);
        re = nre;
        im = nim;
        if (mag > ESCAPE_BOUND) out = 1'b1;
        else i++;
      end
      e.x = x;
      e.y = y;
      e.count = i[ITER_BITS-1:0];
      e.escaped = out;
      expected_escapes.push_back(e);
    endfunction

    task check_result(logic [ITER_BITS-1:0] count, logic escaped);
      escape_t e;
      if (expected_escapes.size() == 0) begin
        report($sformatf("result count=%0d escaped=%0b with no pixel pending", count, escaped));
      end else begin
        e = expected_escapes.pop_front();
        if (count !== e.count || escaped !== e.escaped)
          report($sformatf("pixel (%0d,%0d): count=%0d escaped=%0b, expected %0d/%0b",
                           e.x, e.y, count, escaped, e.count, e.escaped));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PIXEL_BITS-1:0] in_pixel_x = '0;
  logic [PIXEL_BITS-1:0] in_pixel_y = '0;
  logic out_valid;
  logic [ITER_BITS-1:0] out_iteration_count;
  logic out_escaped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  escape_tracker sb = new();
  int idle_pct = 0;
  int quiet_cycles = 0;

  julia_escape_time_pixel uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .out_valid(out_valid),
    .out_iteration_count(out_iteration_count),
    .out_escaped(out_escaped),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_iteration_count, out_escaped);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [PIXEL_BITS-1:0] x, logic [PIXEL_BITS-1:0] y);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(x, y);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_config(logic [ZOOM_BITS-1:0] zm, logic [ITER_BITS-1:0] lim,
                             logic [31:0] cr, logic [31:0] ci,
                             logic [SPAN_BITS-1:0] w, logic [SPAN_BITS-1:0] h);
    write_reg(CFG_ZOOM, 32'(zm));
    write_reg(CFG_LIMIT, 32'(lim));
    write_reg(CFG_CREAL, cr);
    write_reg(CFG_CIMAG, ci);
    write_reg(CFG_WIDTH, 32'(w));
    write_reg(CFG_HEIGHT, 32'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_escapes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  logic [ZOOM_BITS-1:0] r_zoom;
  logic [ITER_BITS-1:0] r_limit;
  logic [31:0] r_cre, r_cim;
  logic [SPAN_BITS-1:0] r_w, r_h;
  logic [PIXEL_BITS-1:0] px, py;
  int n_items;
  int pct_table[3] = '{0, 63, 11};

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd20, 10'd10);
    send_pixel(10'd10, 10'd5);
    send_pixel(10'd30, 10'd15);
    send_pixel(10'd25, 10'd12);
    drain();

    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    load_config(16'd768, 9'd0, 32'hF4CC_CCCD, 32'h0452_8F4E, 9'd40, 9'd20);
    send_pixel(10'd20, 10'd10);
    send_pixel(10'd0, 10'd0);
    drain();

    load_config(16'd0, 9'd64, 32'hF4CC_CCCD, 32'h0452_8F4E, 9'd0, 9'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd1023, 10'd512);
    drain();

    load_config(16'hFFFF, 9'd511, 32'h0, 32'h0, 9'd256, 9'd256);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd128, 10'd128);
    drain();

    load_config(16'd256, 9'd1, 32'h8000_0000, 32'h7FFF_FFFF, 9'd40, 9'd40);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd39, 10'd39);
    drain();

    load_config(16'd1, 9'd256, 32'h7FFF_FFFF, 32'h8000_0000, 9'd1, 9'd2);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd1023, 10'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = pct_table[ph % 3];
      case ($urandom_range(0, 9))
        0: r_zoom = 16'($urandom_range(0, 65535));
        1: r_zoom = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: r_zoom = 16'($urandom_range(128, 1024));
      endcase
      r_limit = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(8, 96));
      if ($urandom_range(0, 5) == 0) begin
        r_cre = $urandom();
        r_cim = $urandom();
      end else begin
        r_cre = 32'hF000_0000 + 32'($urandom_range(0, 32'h0C00_0000));
        r_cim = 32'hF000_0000 + 32'($urandom_range(0, 32'h2000_0000));
      end
      r_w = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(8, 64));
      r_h = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(8, 64));
      load_config(r_zoom, r_limit, r_cre, r_cim, r_w, r_h);
      n_items = $urandom_range(60, 80);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          px = 10'($urandom_range(0, (r_w == 0) ? 0 : r_w - 1));
          py = 10'($urandom_range(0, (r_h == 0) ? 0 : r_h - 1));
        end else begin
          px = 10'($urandom_range(0, 1023));
          py = 10'($urandom_range(0, 1023));
        end
        send_pixel(px, py);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_escapes.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_escapes.size()));
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/jet_pkg.sv
rtl/jet_div.sv
rtl/jet_dp.sv
rtl/jet_ctrl.sv
rtl/julia_escape_time_pixel.sv
bench/julia_escape_time_pixel_tb.sv
